// ----- hw/rtl/sfsr_pkg.sv -----
// shared types and constants for the single float square root block
package sfsr_pkg;

    localparam int unsigned ROOT_STEPS_DEF = 25;
    localparam int unsigned WORD_W = 32;

    localparam logic [31:0] MANT_MASK    = 32'h007f_ffff;
    localparam logic [31:0] EXP_MASK     = 32'h7f80_0000;
    localparam logic [31:0] HIDDEN_BIT   = 32'h0080_0000;
    localparam logic [31:0] EXP_OFS_ODD  = 32'h2000_0000;
    localparam logic [31:0] EXP_OFS_EVEN = 32'h1f80_0000;
    localparam logic [31:0] TOP_BIT      = 32'h8000_0000;
    localparam logic [31:0] ROUND_ADD    = 32'h0000_0100;
    localparam logic [31:0] ROUND_BIT    = 32'h0000_0080;

    typedef enum logic [1:0] {
        STATUS_NORMAL = 2'd0,
        STATUS_ZERO   = 2'd1,
        STATUS_NEG    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1
    } state_t;

    typedef struct packed {
        logic        take;
        logic [31:0] trial;
        logic [31:0] delta;
    } step_res_t;

endpackage

// ----- hw/rtl/sfsr_step.sv -----
// one restoring square root step: shifts, trial sum and compare
module sfsr_step #(
    parameter int unsigned STEP_W = 5
) (
    input  logic [STEP_W-1:0]  step,
    input  logic [31:0]        root,
    input  logic [31:0]        sq,
    input  logic [31:0]        target,
    output sfsr_pkg::step_res_t res
);

    logic [STEP_W:0] step_x;
    logic [STEP_W:0] half_amt;
    logic [31:0]     root_sh;
    logic [31:0]     half;
    logic [31:0]     delta;
    logic [31:0]     trial;

    always_comb
    begin
        step_x   = {1'b0, step};
        half_amt = {step, 1'b1};
        delta    = (step_x >= (STEP_W+1)'(32)) ? 32'd0 : (sfsr_pkg::TOP_BIT >> step);
        root_sh  = (step_x >= (STEP_W+1)'(32)) ? 32'd0 : (root >> step);
        half     = (half_amt >= (STEP_W+1)'(32)) ? 32'd0 : (sfsr_pkg::TOP_BIT >> half_amt);
        trial    = sq + root_sh + half;
        res.take  = (trial <= target);
        res.trial = trial;
        res.delta = delta;
    end

endmodule

// ----- hw/rtl/sfsr_pack.sv -----
// rounding of the root and packing with the halved exponent
module sfsr_pack (
    input  logic [31:0] root,
    input  logic [31:0] expo,
    output logic [31:0] packed_bits
);

    logic [31:0] rounded;

    always_comb
    begin
        rounded     = ((root & sfsr_pkg::ROUND_BIT) != 32'd0) ? (root + sfsr_pkg::ROUND_ADD)
                                                              : root;
        packed_bits = ((rounded >> 8) & sfsr_pkg::MANT_MASK) | expo;
    end

endmodule

// ----- hw/rtl/single_float_square_root_top.sv -----
// top level of the single float square root block: sequencer and registers
//
// usage:
//   raise start with a word on operand_bits while busy is low; the word is
//   taken at that clock edge and busy stays high until the root is done.
//   the result word appears on root_bits and status, marked by done, which is
//   high for exactly one cycle; the receiver cannot stall and must take it then.
// sequence:
//   zero input and a set sign bit finish at once: done is registered at the
//   accepting edge and busy never rises.
//   other words compute one root bit per step on the shared step unit, up to
//   ROOT_STEPS steps, ending early on an exact square; the root is then
//   rounded and packed into a registered result word marked by done.
// throughput:
//   one word at a time; a new word may be taken in the cycle done is high.
// reset:
//   rst_n low clears the sequencer and the done strobe at once; no word is
//   in flight after reset.
module single_float_square_root_top #(
    parameter int unsigned ROOT_STEPS = sfsr_pkg::ROOT_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] operand_bits,
    output logic        done,
    output logic [31:0] root_bits,
    output logic [1:0]  status
);

    localparam int unsigned STEP_W = $clog2(ROOT_STEPS + 1);

    sfsr_pkg::state_t    state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [31:0]         target_reg, target_next;
    logic [31:0]         expo_reg, expo_next;
    logic [31:0]         root_reg, root_next;
    logic [31:0]         sq_reg, sq_next;
    logic                done_reg, done_next;
    logic [31:0]         out_bits_reg, out_bits_next;
    sfsr_pkg::status_t   out_status_reg, out_status_next;

    logic                accept;
    logic                special;
    logic                finish;
    logic [31:0]         target_in;
    sfsr_pkg::step_res_t step_res;
    logic [31:0]         packed_bits;

    sfsr_step #(
        .STEP_W (STEP_W)
    ) u_step (
        .step   (step_reg),
        .root   (root_reg),
        .sq     (sq_reg),
        .target (target_reg),
        .res    (step_res)
    );

    sfsr_pack u_pack (
        .root        (root_reg),
        .expo        (expo_reg),
        .packed_bits (packed_bits)
    );

    assign busy      = (state_reg != sfsr_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign special   = (operand_bits == 32'd0) || operand_bits[31];
    assign finish    = (sq_reg == target_reg) || (step_reg >= STEP_W'(ROOT_STEPS));
    assign target_in = ((operand_bits & sfsr_pkg::MANT_MASK) | sfsr_pkg::HIDDEN_BIT) << 8;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfsr_pkg::ST_IDLE:
            begin
                if (accept && !special)
                begin
                    state_next = sfsr_pkg::ST_RUN;
                end
            end
            sfsr_pkg::ST_RUN:
            begin
                if (finish)
                begin
                    state_next = sfsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfsr_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        step_next       = step_reg;
        target_next     = target_reg;
        expo_next       = expo_reg;
        root_next       = root_reg;
        sq_next         = sq_reg;
        done_next       = 1'b0;
        out_bits_next   = out_bits_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            sfsr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (operand_bits == 32'd0)
                    begin
                        done_next       = 1'b1;
                        out_bits_next   = 32'd0;
                        out_status_next = sfsr_pkg::STATUS_ZERO;
                    end
                    else if (operand_bits[31])
                    begin
                        done_next       = 1'b1;
                        out_bits_next   = operand_bits;
                        out_status_next = sfsr_pkg::STATUS_NEG;
                    end
                    else
                    begin
                        step_next = '0;
                        root_next = 32'd0;
                        sq_next   = 32'd0;
                        if ((operand_bits & sfsr_pkg::HIDDEN_BIT) != 32'd0)
                        begin
                            target_next = target_in >> 1;
                            expo_next   = ((operand_bits >> 1) & sfsr_pkg::EXP_MASK)
                                          + sfsr_pkg::EXP_OFS_ODD;
                        end
                        else
                        begin
                            target_next = target_in;
                            expo_next   = ((operand_bits >> 1) & sfsr_pkg::EXP_MASK)
                                          + sfsr_pkg::EXP_OFS_EVEN;
                        end
                    end
                end
            end
            sfsr_pkg::ST_RUN:
            begin
                if (finish)
                begin
                    done_next       = 1'b1;
                    out_bits_next   = packed_bits;
                    out_status_next = sfsr_pkg::STATUS_NORMAL;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                    if (step_res.take)
                    begin
                        root_next = root_reg + step_res.delta;
                        sq_next   = step_res.trial;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfsr_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        expo_reg       <= expo_next;
        root_reg       <= root_next;
        sq_reg         <= sq_next;
        out_bits_reg   <= out_bits_next;
        out_status_reg <= out_status_next;
    end

    assign done      = done_reg;
    assign root_bits = out_bits_reg;
    assign status    = out_status_reg;

`ifndef SYNTHESIS
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == sfsr_pkg::ST_RUN || accept))
        else $error("done without a word in flight");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(ROOT_STEPS))
        else $error("step counter beyond limit");

    a_target_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfsr_pkg::ST_RUN && $past(state_reg == sfsr_pkg::ST_RUN))
        |-> $stable(target_reg))
        else $error("target changed during root");

    a_sq_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfsr_pkg::ST_RUN) |-> (sq_reg <= target_reg))
        else $error("running square above target");

    a_no_busy_on_special: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && special) |=> !busy && done_reg)
        else $error("special word did not finish at once");
`endif

endmodule

// ----- bench/sfsr_root_checker.sv -----
// checker for the single float square root block: predicts each root word and compares
module sfsr_root_checker #(
    parameter int unsigned ROOT_STEPS = sfsr_pkg::ROOT_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] operand_bits,
    input  logic        done,
    input  logic [31:0] root_bits,
    input  logic [1:0]  status,
    output int unsigned fail_count,
    output int unsigned roots_pending
);

    typedef struct packed {
        logic [31:0]       bits;
        sfsr_pkg::status_t st;
    } root_word_t;

    root_word_t expected_roots [$];
    root_word_t oldest;

    function automatic root_word_t compute_root(input logic [31:0] y);
        root_word_t  r;
        logic [31:0] target;
        logic [31:0] expo;
        logic [31:0] root;
        logic [31:0] sq;
        logic [31:0] delta;
        logic [31:0] trial;
        int unsigned step;
        if (y == 32'h0) begin
            r.bits = 32'h0;
            r.st   = sfsr_pkg::STATUS_ZERO;
        end
        else if (y[31]) begin
            r.bits = y;
            r.st   = sfsr_pkg::STATUS_NEG;
        end
        else begin
            target = ((y & sfsr_pkg::MANT_MASK) | sfsr_pkg::HIDDEN_BIT) << 8;
            if (y[23]) begin
                target = target >> 1;
                expo   = ((y >> 1) & sfsr_pkg::EXP_MASK) + sfsr_pkg::EXP_OFS_ODD;
            end
            else begin
                expo = ((y >> 1) & sfsr_pkg::EXP_MASK) + sfsr_pkg::EXP_OFS_EVEN;
            end
            root = 32'h0;
            sq   = 32'h0;
            step = 0;
            // restoring root, one bit per step, stops on an exact square
            while (sq != target && step < ROOT_STEPS) begin
                delta = (step >= 32) ? 32'h0 : (sfsr_pkg::TOP_BIT >> step);
                trial = sq + ((step >= 32) ? 32'h0 : (root >> step))
                        + ((step + 1 >= 32) ? 32'h0 : (delta >> (step + 1)));
                step++;
                if (trial <= target) begin
                    root = root + delta;
                    sq   = trial;
                end
            end
            if ((root & sfsr_pkg::ROUND_BIT) != 32'h0) begin
                root = root + sfsr_pkg::ROUND_ADD;
            end
            r.bits = ((root >> 8) & sfsr_pkg::MANT_MASK) | expo;
            r.st   = sfsr_pkg::STATUS_NORMAL;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n) begin
            fail_count    = 0;
            roots_pending = 0;
            expected_roots.delete();
        end
        else begin
            if (done) begin
                if (expected_roots.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected word: root_bits %h status %0d",
                                 root_bits, status);
                    end
                end
                else begin
                    oldest = expected_roots.pop_front();
                    if (root_bits !== oldest.bits || status !== oldest.st) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: root_bits exp %h got %h, status exp %0d got %0d",
                                     oldest.bits, root_bits, oldest.st, status);
                        end
                    end
                end
            end
            if (start && !busy) begin
                expected_roots.push_back(compute_root(operand_bits));
            end
            roots_pending = expected_roots.size();
        end
    end

endmodule

// ----- bench/tb_single_float_square_root_top.sv -----
// testbench top for the single float square root block: stimulus, timeout and verdict
module tb_single_float_square_root_top;

    localparam int unsigned RANDOM_WORDS = 1950;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = sfsr_pkg::ROOT_STEPS_DEF + 4;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] operand_bits;
    logic        done;
    logic [31:0] root_bits;
    logic [1:0]  status;

    int unsigned fail_count;
    int unsigned roots_pending;
    int unsigned cycle_count = 0;
    int unsigned burst_left;
    logic [31:0] directed_words [0:17];

    single_float_square_root_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operand_bits (operand_bits),
        .done         (done),
        .root_bits    (root_bits),
        .status       (status)
    );

    sfsr_root_checker CHECK (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operand_bits  (operand_bits),
        .done          (done),
        .root_bits     (root_bits),
        .status        (status),
        .fail_count    (fail_count),
        .roots_pending (roots_pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic idle_gap(input int unsigned cycles);
        @(negedge clk);
        start        <= 1'b0;
        operand_bits <= $urandom;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_all_roots();
        @(negedge clk);
        start <= 1'b0;
        while (roots_pending != 0) @(negedge clk);
    endtask

    task automatic send_word(input logic [31:0] word);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            // some bursts run back to back with no gap
            if ($urandom_range(0, 3) != 0) begin
                idle_gap($urandom_range(1, 20));
            end
        end
        burst_left--;
        @(negedge clk);
        start        <= 1'b1;
        operand_bits <= word;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    function automatic logic [31:0] random_operand();
        int unsigned pick;
        logic [31:0] w;
        pick = $urandom_range(0, 99);
        w    = $urandom;
        if (pick < 5) begin
            w = 32'h0;
        end
        else if (pick < 12) begin
            w[31] = 1'b1;
        end
        else if (pick < 24) begin
            // short mantissa, hits exact squares and early stop
            w = {1'b0, w[30:23], w[22:17], 17'h0};
        end
        else if (pick < 30) begin
            w = {1'b0, w[30:23], 23'h0};
        end
        else if (pick >= 36) begin
            w[31] = 1'b0;
        end
        return w;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operand_bits = 32'h0;
        burst_left   = 0;
        directed_words = '{
            32'h0000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
            32'h3f80_0000, 32'h4080_0000, 32'h4000_0000, 32'h4110_0000,
            32'h0000_0001, 32'h007f_ffff, 32'h0080_0000, 32'h00ff_ffff,
            32'h7f80_0000, 32'h7fc0_0000, 32'hbf80_0000, 32'h3fff_ffff,
            32'h7f7f_ffff, 32'h3f80_0001
        };
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_words[i]) begin
            send_word(directed_words[i]);
        end
        wait_all_roots();

        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            send_word(random_operand());
            if (n % 400 == 399) begin
                wait_all_roots();
            end
        end

        wait_all_roots();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && roots_pending == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
